@@ rtl/mcew_pkg.sv @@
// Package: shared types and constants of the escalating watchdog.
`default_nettype none
package mcew_pkg;
   localparam int DEF_CHANNELS = 8;
   localparam int MAX_RES = 8;

   typedef enum logic [2:0] {
      OP_REGISTER = 3'd0,
      OP_BEAT     = 3'd1,
      OP_CKPT     = 3'd2,
      OP_CHECK    = 3'd3,
      OP_SUCCESS  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_RECOVERED = 3'd1,
      EV_SOFT      = 3'd2,
      EV_REBOOT    = 3'd3,
      EV_REFUSED   = 3'd4,
      EV_BRAKE1    = 3'd5,
      EV_BLOCKED   = 3'd6,
      EV_REARM     = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_ALREADY = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EVAL, S_EMIT, S_NEXT, S_DONE
   } state_type;

   localparam logic [0:0] CSR_BRAKE_LIMIT = 1'b0;
   localparam logic [0:0] CSR_HOOK        = 1'b1;

   typedef struct packed {
      logic [2:0]  channel_out;
      logic [2:0]  event_res;
      logic [1:0]  status;
      logic [7:0]  soft_count_out;
      logic [15:0] checkpoint_out;
      logic [31:0] elapsed_ms;
      logic        recover_request;
      logic [7:0]  brake_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  channel;
      logic [31:0] now_ms;
      logic [31:0] expiry_ms;
      logic [7:0]  soft_limit;
      logic        escalate_enable;
      logic        recover_present;
      logic        probe_present;
      logic [15:0] checkpoint_value;
      logic [7:0]  probe_allow_mask;
      logic        reboot_accept;
   } req_type;

   typedef struct packed {
      logic [1:0] index;
      logic [7:0] data;
   } csr_type;
endpackage
`default_nettype wire

@@ rtl/mcew_if.sv @@
// Interfaces: valid/ready channels for requests, results and CSR writes.
`default_nettype none
interface mcew_req_if import mcew_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mcew_rsp_if import mcew_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mcew_csr_if import mcew_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/multi_channel_escalating_watchdog_unit.sv @@
// Top level: escalating multi-channel watchdog with a sequenced channel walk.
//
//  channel  | dir | contents
//  req_     | in  | op, channel, time, registration and check fields
//  rsp_     | out | one or more results per request, last marks the final one
//  csr_     | in  | index 0 brake_limit, 1 reboot_hook_present
//
// One request is in work at a time; req_ready is low until its last result is
// in the output register. A check walks all CHANNELS entries, each through RAM
// read, subtract, compare/write-back/emit and advance. Synchronous reset
// clears per-channel flags and counts; deadline, soft limit, flags and beat
// time are RAM and need no clear.
// The output register holds a result until rsp_ready; the walk stalls there.
`default_nettype none
module multi_channel_escalating_watchdog_unit
   import mcew_pkg::*;
#(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mcew_req_if.sink   req,
   mcew_rsp_if.source rsp,
   mcew_csr_if.sink   csr
);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration
   logic [7:0] brake_limit_ff;
   logic       hook_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         brake_limit_ff <= 8'd3;
         hook_ff        <= 1'b1;
      end else if (csr.valid) begin
         if (csr.data.index == {1'b0, CSR_BRAKE_LIMIT}) brake_limit_ff <= csr.data.data;
         else if (csr.data.index == {1'b0, CSR_HOOK}) hook_ff <= csr.data.data[0];
      end
   end

   // per-channel flop state with reset values
   logic [CHANNELS-1:0] used_ff, tmo_ff, noted_ff;
   logic [7:0]  soft_ff [CHANNELS];
   logic [15:0] ckpt_ff [CHANNELS];
   logic [7:0]  rws_ff;

   // RAM: {deadline, soft_max, flags} written at registration; beat time separate
   localparam int CFG_W = 32 + 8 + 3;
   logic          cfg_we, beat_we;
   logic [CW-1:0] wr_ch, rd_ch;
   logic [CFG_W-1:0] cfg_wd, cfg_rd;
   logic [31:0]   beat_wd, beat_rd;

   mcew_ram #(.WIDTH(CFG_W), .DEPTH(CHANNELS)) u_cfg_ram (
      .clock(clock), .wr_en(cfg_we), .wr_addr(wr_ch), .wr_data(cfg_wd),
      .rd_addr(rd_ch), .rd_data(cfg_rd));
   mcew_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_beat_ram (
      .clock(clock), .wr_en(beat_we), .wr_addr(wr_ch), .wr_data(beat_wd),
      .rd_addr(rd_ch), .rd_data(beat_rd));

   // sequencer
   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW:0] idx_ff, idx_in;   // walk index, one extra bit for end
   logic [3:0]  nres_ff, nres_in; // results emitted in this check
   logic [31:0] el_ff, el_in;     // shared subtractor output, registered
   rsp_type   out_ff, out_in;
   logic      ovld_ff, ovld_in;
   logic      pend_ff, pend_in;   // a check result is held back for last flag
   rsp_type   pend_res_ff, pend_res_in;

   wire [CW-1:0] idx = idx_ff[CW-1:0];
   wire [31:0]   idx_w = 32'(idx_ff);
   wire          ch_ok = ({29'd0, req_ff.channel} < 32'(CHANNELS));
   wire [CW-1:0] req_ch = CW'(req_ff.channel);

   // write-side regs
   logic [CHANNELS-1:0] used_in, tmo_in, noted_in;
   logic [7:0]  soft_wr, rws_in;
   logic        soft_we, ckpt_we;
   logic [CW-1:0] st_ch;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ovld_ff;
   assign rsp.data  = out_ff;
   assign rd_ch     = (state_ff == S_IDLE) ? '0 :
                      (req_ff.op == OP_CHECK) ? idx : req_ch;

   always_comb begin
      logic [31:0] dl;
      logic [7:0]  smax;
      logic [2:0]  fl;
      logic [2:0]  ev;
      logic        rr;
      logic        allow;
      rsp_type     r;
      state_in    = state_ff;
      idx_in      = idx_ff;
      nres_in     = nres_ff;
      el_in       = el_ff;
      out_in      = out_ff;
      ovld_in     = ovld_ff && !rsp.ready;
      pend_in     = pend_ff;
      pend_res_in = pend_res_ff;
      used_in     = used_ff;
      tmo_in      = tmo_ff;
      noted_in    = noted_ff;
      rws_in      = rws_ff;
      soft_we     = 1'b0;
      soft_wr     = '0;
      ckpt_we     = 1'b0;
      st_ch       = req_ch;
      cfg_we      = 1'b0;
      beat_we     = 1'b0;
      wr_ch       = req_ch;
      cfg_wd      = {req_ff.expiry_ms, req_ff.soft_limit, req_ff.probe_present,
                     req_ff.recover_present, req_ff.escalate_enable};
      beat_wd     = req_ff.now_ms;
      {dl, smax, fl} = cfg_rd;
      ev          = EV_NONE;
      rr          = 1'b0;
      allow       = 1'b0;
      r           = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in  = '0;
            nres_in = '0;
            pend_in = 1'b0;
            if (req.valid) state_in = S_READ;
         end
         S_READ: begin
            // RAM read of rd_ch lands at the end of this cycle
            state_in = S_EVAL;
         end
         S_EVAL: begin
            el_in = req_ff.now_ms - beat_rd;
            if (req_ff.op == OP_CHECK) state_in = S_EMIT;
            else if (!ovld_ff || rsp.ready) begin
               r.channel_out = req_ff.channel;
               r.last        = 1'b1;
               if (ch_ok) begin
                  r.soft_count_out = soft_ff[req_ch];
                  r.checkpoint_out = ckpt_ff[req_ch];
               end
               unique case (req_ff.op)
                  OP_REGISTER: begin
                     if (!ch_ok || req_ff.expiry_ms == '0) begin
                        r.status = ST_INVALID;
                        r.soft_count_out = '0;
                        r.checkpoint_out = '0;
                     end else if (used_ff[req_ch]) r.status = ST_ALREADY;
                     else begin
                        used_in[req_ch] = 1'b1;
                        cfg_we  = 1'b1;
                        beat_we = 1'b1;
                     end
                  end
                  OP_BEAT, OP_CKPT: begin
                     if (!ch_ok || !used_ff[req_ch]) r.status = ST_UNUSED;
                     else if (req_ff.op == OP_BEAT) begin
                        r.event_res = tmo_ff[req_ch] ? EV_RECOVERED : EV_NONE;
                        beat_we = 1'b1;
                        soft_we = 1'b1;
                        tmo_in[req_ch]   = 1'b0;
                        noted_in[req_ch] = 1'b0;
                     end else begin
                        ckpt_we = 1'b1;
                        r.checkpoint_out = req_ff.checkpoint_value;
                     end
                  end
                  OP_SUCCESS: begin
                     r = '0;
                     r.last = 1'b1;
                     rws_in = '0;
                  end
                  default: r.status = ST_INVALID;
               endcase
               r.brake_count = (req_ff.op == OP_SUCCESS) ? 8'd0 : rws_ff;
               out_in   = r;
               ovld_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // one channel of the walk: decide stage, write back, queue result
            st_ch = idx;
            wr_ch = idx;
            if (used_ff[idx] && el_ff >= dl) begin
               if (pend_ff && ovld_ff && !rsp.ready) begin
                  state_in = S_EMIT; // wait for output register
               end else begin
                  tmo_in[idx] = 1'b1;
                  beat_we = 1'b1;
                  soft_wr = soft_ff[idx];
                  if (soft_ff[idx] < smax) begin
                     soft_wr = soft_ff[idx] + 8'd1;
                     soft_we = 1'b1;
                     ev = EV_SOFT;
                     rr = fl[1];
                  end else if (fl[0]) begin
                     rr = fl[1];
                     allow = (idx_w < 32'd8) && req_ff.probe_allow_mask[idx_w[2:0]];
                     if (fl[2] && !allow) ev = EV_BLOCKED;
                     else if (rws_ff >= brake_limit_ff) begin
                        if (!noted_ff[idx]) begin
                           noted_in[idx] = 1'b1;
                           ev = EV_BRAKE1;
                        end else ev = EV_BLOCKED;
                     end else if (!hook_ff) ev = EV_BLOCKED;
                     else begin
                        if (rws_ff != 8'hFF) rws_in = rws_ff + 8'd1;
                        ev = req_ff.reboot_accept ? EV_REBOOT : EV_REFUSED;
                     end
                  end else ev = EV_REARM;
                  if (nres_ff < 4'(MAX_RES)) begin
                     if (pend_ff) begin
                        out_in  = pend_res_ff;
                        ovld_in = 1'b1;
                     end
                     r.channel_out     = idx_w[2:0];
                     r.event_res       = ev;
                     r.soft_count_out  = soft_wr;
                     r.checkpoint_out  = ckpt_ff[idx];
                     r.elapsed_ms      = el_ff;
                     r.recover_request = rr;
                     // brake count as it stands after this channel's stage
                     r.brake_count     = rws_in;
                     pend_res_in = r;
                     pend_in     = 1'b1;
                     nres_in     = nres_ff + 4'd1;
                  end
                  state_in = S_NEXT;
               end
            end else state_in = S_NEXT;
         end
         S_NEXT: begin
            if (idx_ff == (CW+1)'(CHANNELS - 1)) state_in = S_DONE;
            else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!ovld_ff || rsp.ready) begin
               out_in = pend_ff ? pend_res_ff : rsp_type'(0);
               if (!pend_ff) out_in.brake_count = rws_ff;
               out_in.last = 1'b1;
               ovld_in  = 1'b1;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovld_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         used_ff  <= '0;
         tmo_ff   <= '0;
         noted_ff <= '0;
         rws_ff   <= '0;
         idx_ff   <= '0;
         nres_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            soft_ff[i] <= '0;
            ckpt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         pend_ff  <= pend_in;
         used_ff  <= used_in;
         tmo_ff   <= tmo_in;
         noted_ff <= noted_in;
         rws_ff   <= rws_in;
         idx_ff   <= idx_in;
         nres_ff  <= nres_in;
         if (soft_we) soft_ff[st_ch] <= soft_wr;
         if (ckpt_we) ckpt_ff[st_ch] <= req_ff.checkpoint_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) req_ff <= req.data;
      el_ff       <= el_in;
      out_ff      <= out_in;
      pend_res_ff <= pend_res_in;
   end
endmodule
`default_nettype wire

@@ rtl/mcew_ram.sv @@
// Generic RAM: one write port, one registered read port.
`default_nettype none
module mcew_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                   rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ sim/tb_multi_channel_escalating_watchdog_unit.sv @@
// Testbench: random and directed stimulus of the watchdog against a behavioural predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_multi_channel_escalating_watchdog_unit import mcew_pkg::*; ();

   // Scoreboard: holds its own copy of the watchdog state and the queue of
   // results still to come.
   class wd_scoreboard;
      rsp_type     pending[$];
      int          errors;
      logic [7:0]  brake_lim;
      logic        hook;
      logic        used[8];
      logic [31:0] beat_at[8];
      logic [7:0]  soft_cnt[8];
      logic        timed_out[8];
      logic        brake_seen[8];
      logic [15:0] ckpt[8];
      logic [31:0] dline[8];
      logic [7:0]  soft_max[8];
      logic        f_esc[8], f_rec[8], f_probe[8];
      logic [7:0]  reboots;

      function new();
         errors = 0;
         brake_lim = 8'd3;
         hook = 1'b1;
         reboots = 8'd0;
         for (int c = 0; c < 8; c++) begin
            used[c] = '0; soft_cnt[c] = '0; timed_out[c] = '0; brake_seen[c] = '0;
            ckpt[c] = '0; beat_at[c] = '0; dline[c] = '0; soft_max[c] = '0;
            f_esc[c] = '0; f_rec[c] = '0; f_probe[c] = '0;
         end
      endfunction

      function void csr_write(csr_type w);
         if (w.index == CSR_BRAKE_LIMIT) brake_lim = w.data;
         else if (w.index == CSR_HOOK) hook = w.data[0];
      endfunction

      function rsp_type mk(logic [2:0] ch, event_type ev, status_type st, logic [7:0] sc,
                           logic [15:0] cp, logic [31:0] el, logic rr);
         rsp_type r;
         r.channel_out = ch; r.event_res = ev; r.status = st; r.soft_count_out = sc;
         r.checkpoint_out = cp; r.elapsed_ms = el; r.recover_request = rr;
         r.brake_count = reboots; r.last = 1'b0;
         return r;
      endfunction

      function event_type escalation(int c, logic [7:0] allow, logic accept);
         if (f_probe[c] && !allow[c]) return EV_BLOCKED;
         if (reboots >= brake_lim) begin
            if (!brake_seen[c]) begin
               brake_seen[c] = 1'b1;
               return EV_BRAKE1;
            end
            return EV_BLOCKED;
         end
         if (!hook) return EV_BLOCKED;
         if (reboots != 8'hFF) reboots++;
         return accept ? EV_REBOOT : EV_REFUSED;
      endfunction

      // Note an accepted request and queue the results it causes.
      function void note_request(req_type q);
         rsp_type   res[$];
         int        c;
         logic [31:0] el;
         event_type ev;
         logic      rr;
         rsp_type   r;
         c = q.channel;
         case (q.op)
            OP_REGISTER: begin
               if (q.expiry_ms == 0)
                  res.push_back(mk(q.channel, EV_NONE, ST_INVALID, 8'd0, 16'd0, 32'd0, 1'b0));
               else if (used[c])
                  res.push_back(mk(q.channel, EV_NONE, ST_ALREADY, soft_cnt[c], ckpt[c],
                                   32'd0, 1'b0));
               else begin
                  used[c] = 1'b1; dline[c] = q.expiry_ms; soft_max[c] = q.soft_limit;
                  f_esc[c] = q.escalate_enable; f_rec[c] = q.recover_present;
                  f_probe[c] = q.probe_present; beat_at[c] = q.now_ms;
                  res.push_back(mk(q.channel, EV_NONE, ST_OK, soft_cnt[c], ckpt[c],
                                   32'd0, 1'b0));
               end
            end
            OP_BEAT, OP_CKPT: begin
               if (!used[c])
                  res.push_back(mk(q.channel, EV_NONE, ST_UNUSED, soft_cnt[c], ckpt[c],
                                   32'd0, 1'b0));
               else if (q.op == OP_BEAT) begin
                  r = mk(q.channel, timed_out[c] ? EV_RECOVERED : EV_NONE, ST_OK, soft_cnt[c],
                         ckpt[c], 32'd0, 1'b0);
                  beat_at[c] = q.now_ms; soft_cnt[c] = '0; timed_out[c] = 1'b0;
                  brake_seen[c] = 1'b0;
                  res.push_back(r);
               end else begin
                  ckpt[c] = q.checkpoint_value;
                  res.push_back(mk(q.channel, EV_NONE, ST_OK, soft_cnt[c], ckpt[c],
                                   32'd0, 1'b0));
               end
            end
            OP_CHECK: begin
               for (int k = 0; k < 8; k++) begin
                  if (!used[k]) continue;
                  el = q.now_ms - beat_at[k];
                  if (el < dline[k]) continue;
                  timed_out[k] = 1'b1;
                  rr = 1'b0;
                  if (soft_cnt[k] < soft_max[k]) begin
                     soft_cnt[k]++; ev = EV_SOFT; rr = f_rec[k];
                  end else if (f_esc[k]) begin
                     ev = escalation(k, q.probe_allow_mask, q.reboot_accept); rr = f_rec[k];
                  end else ev = EV_REARM;
                  beat_at[k] = q.now_ms;
                  if (res.size() < MAX_RES)
                     res.push_back(mk(k[2:0], ev, ST_OK, soft_cnt[k], ckpt[k], el, rr));
               end
               if (res.size() == 0)
                  res.push_back(mk(3'd0, EV_NONE, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0));
            end
            OP_SUCCESS: begin
               reboots = '0;
               res.push_back(mk(3'd0, EV_NONE, ST_OK, 8'd0, 16'd0, 32'd0, 1'b0));
            end
            default: res.push_back(mk(q.channel, EV_NONE, ST_INVALID, soft_cnt[c], ckpt[c],
                                      32'd0, 1'b0));
         endcase
         res[res.size()-1].last = 1'b1;
         foreach (res[i]) pending.push_back(res[i]);
      endfunction

      // Compare one accepted result against the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t mismatch: expected %p actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   mcew_req_if req();
   mcew_rsp_if rsp();
   mcew_csr_if csr();

   multi_channel_escalating_watchdog_unit i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   wd_scoreboard wd_model = new();
   int           send_idle_pct = 0;   // chance per cycle of a gap on the request side
   int           recv_stall_pct = 0;  // chance per cycle of a stall on the result side
   int           quiet_cycles = 0;
   logic [31:0]  clk_ms = 0;          // running notion of time for stimulus

   initial begin
      req.valid = 1'b0; req.data = '0;
      csr.valid = 1'b0; csr.data = '0;
      rsp.ready = 1'b0;
   end

   // Result side: random stalls, compare on every transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) wd_model.check_result(rsp.data);
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // No-progress watchdog: a correct run never goes this long without a transfer.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("[multi_channel_escalating_watchdog_unit] ERROR");
         $finish;
      end
   end

   task automatic send_req(req_type q);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req.valid <= 1'b1;
      req.data  <= q;
      do @(posedge clock); while (!req.ready);
      wd_model.note_request(q);
      req.valid <= 1'b0;
      @(posedge clock);   // block is busy with this request anyway
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] value);
      csr_type w;
      w.index = idx; w.data = value;
      csr.valid <= 1'b1;
      csr.data  <= w;
      do @(posedge clock); while (!csr.ready);
      wd_model.csr_write(w);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Quiesce: every result back, then room for any walk still running.
   task automatic drain();
      while (wd_model.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type mk_req(op_type op, logic [2:0] ch);
      req_type q;
      q = '0;
      q.op = op; q.channel = ch; q.now_ms = clk_ms;
      return q;
   endfunction

   function automatic req_type rand_req();
      req_type q;
      int      pick;
      q = '0;
      q.op = 3'($urandom_range(4));
      q.channel = 3'($urandom_range(7));
      pick = $urandom_range(99);
      // time mostly advances in plausible steps; sometimes jumps or wraps
      if (pick < 80) clk_ms = clk_ms + 32'($urandom_range(1500));
      else if (pick < 90) clk_ms = $urandom;
      q.now_ms = clk_ms;
      case ($urandom_range(5))
         0: q.expiry_ms = 32'd0;
         1: q.expiry_ms = 32'hFFFF_FFFF;
         2: q.expiry_ms = $urandom;
         default: q.expiry_ms = 32'(1000 + $urandom_range(2000));
      endcase
      q.soft_limit = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                                8'($urandom_range(3));
      q.escalate_enable = ($urandom_range(3) != 0);
      q.recover_present = 1'($urandom);
      q.probe_present = 1'($urandom);
      q.checkpoint_value = 16'($urandom);
      q.probe_allow_mask = 8'($urandom);
      q.reboot_accept = 1'($urandom);
      if ($urandom_range(49) == 0) q.op = 3'(5 + $urandom_range(2));
      // beats are rarer so that channels expire and escalate
      if (q.op == OP_BEAT && $urandom_range(2) != 0) q.op = OP_CHECK;
      return q;
   endfunction

   initial begin
      req_type q;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every op, the extremes, the brake and gating cases.
      send_req(mk_req(OP_BEAT, 3'd2));                  // unused channel
      send_req(mk_req(OP_CKPT, 3'd7));
      send_req(mk_req(OP_CHECK, 3'd0));                 // nothing expires
      q = mk_req(OP_REGISTER, 3'd0); send_req(q);       // zero deadline rejected
      q.expiry_ms = 32'd1000; q.soft_limit = 8'd1; q.escalate_enable = 1'b1;
      q.recover_present = 1'b1;
      send_req(q);
      send_req(q);                                      // already registered
      q = mk_req(OP_REGISTER, 3'd7); q.expiry_ms = 32'hFFFF_FFFF; q.soft_limit = 8'hFF;
      q.probe_present = 1'b1; q.escalate_enable = 1'b1; send_req(q);
      q = mk_req(OP_REGISTER, 3'd3); q.expiry_ms = 32'd1; q.probe_present = 1'b1;
      q.escalate_enable = 1'b1; send_req(q);
      q = mk_req(OP_REGISTER, 3'd5); q.expiry_ms = 32'd1; send_req(q);   // rearm only
      q = mk_req(OP_CKPT, 3'd0); q.checkpoint_value = 16'hFFFF; send_req(q);
      for (int i = 0; i < 7; i++) begin
         clk_ms += 1000;
         q = mk_req(OP_CHECK, 3'd0);
         q.probe_allow_mask = (i < 3) ? 8'h00 : 8'hFF;
         q.reboot_accept = i[0];
         send_req(q);
      end
      send_req(mk_req(OP_BEAT, 3'd0));                  // recovered
      send_req(mk_req(OP_SUCCESS, 3'd0));
      q = mk_req(OP_CHECK, 3'd0); q.op = 3'd7; send_req(q); // unknown op
      clk_ms = 32'hFFFF_FFF0;
      q = mk_req(OP_CHECK, 3'd0); q.probe_allow_mask = 8'hFF; q.reboot_accept = 1'b1;
      send_req(q);
      drain();

      // Random phases, each with a register setting; the idling mix cycles through four.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         case (ph)
            0: write_csr(2'(CSR_BRAKE_LIMIT), 8'd0);
            1: write_csr(2'(CSR_BRAKE_LIMIT), 8'd255);
            2: write_csr(2'(CSR_HOOK), 8'd0);
            3: write_csr(2'(CSR_HOOK), 8'd1);
            default: write_csr(2'(CSR_BRAKE_LIMIT), 8'($urandom_range(6)));
         endcase
         if (ph == 6) write_csr(2'(CSR_HOOK), 8'($urandom_range(1)));
         for (int i = 0; i < 47; i++) begin
            q = rand_req();
            send_req(q);
            // after a check, often a follow-up beat on a random channel
            if (q.op == OP_CHECK && $urandom_range(3) == 0) begin
               q = mk_req(OP_BEAT, 3'($urandom_range(7)));
               send_req(q);
            end
         end
         drain();
      end

      while (wd_model.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (wd_model.errors == 0) $display("[multi_channel_escalating_watchdog_unit] OK");
      else $display("[multi_channel_escalating_watchdog_unit] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
